// ----- rtl/core/kpq_pkg.sv -----
// shared types and constants of the keyed priority task queue
// no dependencies; used by every file under rtl/core
package kpq_pkg;

  // default sizes of the task table
  localparam int unsigned ENTRIES_DEF   = 16;
  localparam int unsigned ID_BITS_DEF   = 16;
  localparam int unsigned PRIO_BITS_DEF = 32;

  // stream field widths and positions
  localparam int unsigned OP_W      = 2;
  localparam int unsigned USER_W    = 16;
  localparam int unsigned TASK_W    = 16;
  localparam int unsigned PRIO_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned USER_LSB  = 0;
  localparam int unsigned TASK_LSB  = USER_LSB + USER_W;
  localparam int unsigned PRIO_LSB  = TASK_LSB + TASK_W;
  localparam int unsigned S_TDATA_W = PRIO_LSB + PRIO_W;
  localparam int unsigned M_TDATA_W = USER_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_EDIT   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EXEC   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUP       = 3'd4
  } st_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_APPLY = 2'd2
  } state_e;

  // broadcast control to every cell of the chain
  typedef struct packed {
    logic rm_head;  // drop the head cell
    logic rm_key;   // drop the cell whose key equals the matched key
    logic ins;      // insert the request key
    logic upd;      // commit this cycle
  } ctl_t;

  // flags a cell hands to its neighbors
  typedef struct packed {
    logic a;  // cell sits at or after the removed position
    logic g;  // insert key ranks above this cell
  } nb_t;

endpackage

// ----- rtl/core/kpq_cell.sv -----
// one cell of the sorted task chain: holds one task, shifts with its neighbors
// depends on kpq_pkg
module kpq_cell #(
  parameter int unsigned ID_BITS   = kpq_pkg::ID_BITS_DEF,
  parameter int unsigned PRIO_BITS = kpq_pkg::PRIO_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kpq_pkg::ctl_t                  ctl_i,
  input  logic [PRIO_BITS+ID_BITS-1:0]   ins_key_i,
  input  logic [ID_BITS-1:0]             ins_user_i,
  input  logic [PRIO_BITS+ID_BITS-1:0]   rm_key_i,
  input  logic [ID_BITS-1:0]             task_i,
  input  logic                           l_valid_i,
  input  logic [PRIO_BITS+ID_BITS-1:0]   l_key_i,
  input  logic [ID_BITS-1:0]             l_user_i,
  input  kpq_pkg::nb_t                   l_flg_i,
  input  logic                           r_valid_i,
  input  logic [PRIO_BITS+ID_BITS-1:0]   r_key_i,
  input  logic [ID_BITS-1:0]             r_user_i,
  input  kpq_pkg::nb_t                   r_flg_i,
  output logic                           valid_o,
  output logic [PRIO_BITS+ID_BITS-1:0]   key_o,
  output logic [ID_BITS-1:0]             user_o,
  output kpq_pkg::nb_t                   flg_o,
  output logic                           match_o
);

  localparam int unsigned KEY_W = PRIO_BITS + ID_BITS;

  logic              valid_q, valid_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [ID_BITS-1:0] user_q, user_d;
  kpq_pkg::nb_t      flg;
  logic              fl_self, fl_left;

  // local flags, compared against the broadcast keys
  always_comb begin
    flg.a = ctl_i.rm_head | (ctl_i.rm_key & (!valid_q || key_q <= rm_key_i));
    flg.g = ctl_i.ins & (!valid_q || ins_key_i > key_q);
  end

  // insert flags of the list with the removed entry squeezed out
  assign fl_self = flg.a ? r_flg_i.g : flg.g;
  assign fl_left = l_flg_i.a ? flg.g : l_flg_i.g;

  always_comb begin
    priority if (fl_self && !fl_left) begin
      valid_d = 1'b1;
      key_d   = ins_key_i;
      user_d  = ins_user_i;
    end else if (fl_left) begin
      // shift right: take the left neighbor, or stay when it was squeezed out
      valid_d = l_flg_i.a ? valid_q : l_valid_i;
      key_d   = l_flg_i.a ? key_q   : l_key_i;
      user_d  = l_flg_i.a ? user_q  : l_user_i;
    end else begin
      valid_d = flg.a ? r_valid_i : valid_q;
      key_d   = flg.a ? r_key_i   : key_q;
      user_d  = flg.a ? r_user_i  : user_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.upd) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      key_q  <= key_d;
      user_q <= user_d;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign user_o  = user_q;
  assign flg_o   = flg;
  assign match_o = valid_q && (key_q[ID_BITS-1:0] == task_i);

endmodule

// ----- rtl/core/kpq_chain.sv -----
// row of kpq_cell instances kept sorted by priority then task id, head first
// depends on kpq_pkg and kpq_cell
module kpq_chain #(
  parameter int unsigned ENTRIES   = kpq_pkg::ENTRIES_DEF,
  parameter int unsigned ID_BITS   = kpq_pkg::ID_BITS_DEF,
  parameter int unsigned PRIO_BITS = kpq_pkg::PRIO_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kpq_pkg::ctl_t                  ctl_i,
  input  logic [PRIO_BITS+ID_BITS-1:0]   ins_key_i,
  input  logic [ID_BITS-1:0]             ins_user_i,
  input  logic [PRIO_BITS+ID_BITS-1:0]   rm_key_i,
  input  logic [ID_BITS-1:0]             task_i,
  output logic                           hit_o,
  output logic [PRIO_BITS+ID_BITS-1:0]   hit_key_o,
  output logic [ID_BITS-1:0]             hit_user_o,
  output logic                           head_valid_o,
  output logic [ID_BITS-1:0]             head_user_o,
  output logic                           full_o
);

  localparam int unsigned KEY_W = PRIO_BITS + ID_BITS;

  logic               c_valid [ENTRIES];
  logic [KEY_W-1:0]   c_key   [ENTRIES];
  logic [ID_BITS-1:0] c_user  [ENTRIES];
  kpq_pkg::nb_t       c_flg   [ENTRIES];
  logic               c_match [ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic               l_valid, r_valid;
    logic [KEY_W-1:0]   l_key, r_key;
    logic [ID_BITS-1:0] l_user, r_user;
    kpq_pkg::nb_t       l_flg, r_flg;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_key   = '0;
      assign l_user  = '0;
      assign l_flg   = '0;
    end else begin : g_mid_l
      assign l_valid = c_valid[i-1];
      assign l_key   = c_key[i-1];
      assign l_user  = c_user[i-1];
      assign l_flg   = c_flg[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      // beyond the tail sits an empty cell
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_user  = '0;
      assign r_flg.a = ctl_i.rm_head | ctl_i.rm_key;
      assign r_flg.g = ctl_i.ins;
    end else begin : g_mid_r
      assign r_valid = c_valid[i+1];
      assign r_key   = c_key[i+1];
      assign r_user  = c_user[i+1];
      assign r_flg   = c_flg[i+1];
    end

    kpq_cell #(
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_i),
      .ins_key_i  (ins_key_i),
      .ins_user_i (ins_user_i),
      .rm_key_i   (rm_key_i),
      .task_i     (task_i),
      .l_valid_i  (l_valid),
      .l_key_i    (l_key),
      .l_user_i   (l_user),
      .l_flg_i    (l_flg),
      .r_valid_i  (r_valid),
      .r_key_i    (r_key),
      .r_user_i   (r_user),
      .r_flg_i    (r_flg),
      .valid_o    (c_valid[i]),
      .key_o      (c_key[i]),
      .user_o     (c_user[i]),
      .flg_o      (c_flg[i]),
      .match_o    (c_match[i])
    );
  end

  // ids are unique, so at most one cell matches and an or-merge selects it
  always_comb begin
    hit_o      = 1'b0;
    hit_key_o  = '0;
    hit_user_o = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_o      = hit_o | c_match[i];
      hit_key_o  = hit_key_o | ({KEY_W{c_match[i]}} & c_key[i]);
      hit_user_o = hit_user_o | ({ID_BITS{c_match[i]}} & c_user[i]);
    end
  end

  assign head_valid_o = c_valid[0];
  assign head_user_o  = c_user[0];
  assign full_o       = c_valid[ENTRIES-1];

endmodule

// ----- rtl/core/keyed_priority_task_queue_top.sv -----
// keyed priority task queue: each item runs through a lookup state (S_SCAN) over all
// cells, then a commit state (S_APPLY) in which the whole chain shifts at once
// the result is registered at commit, and commit waits for room in the result register;
// a new item is taken in the commit cycle of the previous one
// the result register lets the next item start while a result is pending
// rst_ni clears the table and the handshake state asynchronously
// depends on kpq_pkg, kpq_chain and kpq_cell
module keyed_priority_task_queue_top #(
  parameter int unsigned ENTRIES   = kpq_pkg::ENTRIES_DEF,
  parameter int unsigned ID_BITS   = kpq_pkg::ID_BITS_DEF,
  parameter int unsigned PRIO_BITS = kpq_pkg::PRIO_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // user_id [15:0], task_id [31:16], priority_req [63:32]
  input  logic [kpq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // op [1:0]
  input  logic [kpq_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // served_user [15:0]
  output logic [kpq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status [2:0]
  output logic [kpq_pkg::STATUS_W-1:0]   m_axis_tuser
);

  localparam int unsigned KEY_W = PRIO_BITS + ID_BITS;
  localparam int unsigned UW    = kpq_pkg::USER_W;

  // handshake state
  kpq_pkg::state_e state_q, state_d;
  logic            in_fire, scan_en, apply_en, out_free;

  // request registers, loaded when an item is accepted
  kpq_pkg::op_e         req_op_q;
  logic [ID_BITS-1:0]   req_user_q, req_task_q;
  logic [PRIO_BITS-1:0] req_prio_q;

  // lookup results, captured in the scan cycle
  logic               hit_q;
  logic [KEY_W-1:0]   hit_key_q;
  logic [ID_BITS-1:0] hit_user_q;

  // chain interface
  kpq_pkg::ctl_t      ctl;
  logic [ID_BITS-1:0] ins_user;
  logic               hit;
  logic [KEY_W-1:0]   hit_key;
  logic [ID_BITS-1:0] hit_user;
  logic               head_valid, full;
  logic [ID_BITS-1:0] head_user;

  // result register
  logic            out_valid_q;
  logic [UW-1:0]   out_user_q, out_user_d;
  kpq_pkg::st_e    out_status_q, out_status_d;

  assign out_free = !out_valid_q || m_axis_tready;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kpq_pkg::S_IDLE: begin
        if (s_axis_tvalid) state_d = kpq_pkg::S_SCAN;
      end
      kpq_pkg::S_SCAN: begin
        state_d = kpq_pkg::S_APPLY;
      end
      kpq_pkg::S_APPLY: begin
        // commit waits for room in the result register
        if (out_free) state_d = s_axis_tvalid ? kpq_pkg::S_SCAN : kpq_pkg::S_IDLE;
      end
      default: begin
        state_d = kpq_pkg::S_IDLE;
      end
    endcase
  end

  // handshake outputs and phase strobes
  always_comb begin
    s_axis_tready = 1'b0;
    scan_en       = 1'b0;
    apply_en      = 1'b0;
    unique case (state_q)
      kpq_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
      end
      kpq_pkg::S_SCAN: begin
        scan_en = 1'b1;
      end
      kpq_pkg::S_APPLY: begin
        apply_en      = out_free;
        s_axis_tready = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture, fields cut or zero-extended to the table widths
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_op_q   <= kpq_pkg::op_e'(s_axis_tuser);
      req_user_q <= ID_BITS'(s_axis_tdata[kpq_pkg::USER_LSB +: kpq_pkg::USER_W]);
      req_task_q <= ID_BITS'(s_axis_tdata[kpq_pkg::TASK_LSB +: kpq_pkg::TASK_W]);
      req_prio_q <= PRIO_BITS'(s_axis_tdata[kpq_pkg::PRIO_LSB +: kpq_pkg::PRIO_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_en) begin
      hit_q      <= hit;
      hit_key_q  <= hit_key;
      hit_user_q <= hit_user;
    end
  end

  // decode the operation into chain control and the result item
  always_comb begin
    ctl          = '0;
    ins_user     = req_user_q;
    out_user_d   = '0;
    out_status_d = kpq_pkg::ST_OK;
    unique case (req_op_q)
      kpq_pkg::OP_ADD: begin
        if (hit_q) begin
          out_status_d = kpq_pkg::ST_DUP;
        end else if (full) begin
          out_status_d = kpq_pkg::ST_FULL;
        end else begin
          ctl.ins = 1'b1;
        end
      end
      kpq_pkg::OP_EDIT: begin
        // edit is a keyed removal plus a reinsert that keeps the user
        ins_user = hit_user_q;
        if (!hit_q) begin
          out_status_d = kpq_pkg::ST_NOT_FOUND;
        end else begin
          ctl.rm_key = 1'b1;
          ctl.ins    = 1'b1;
        end
      end
      kpq_pkg::OP_REMOVE: begin
        if (!hit_q) begin
          out_status_d = kpq_pkg::ST_NOT_FOUND;
        end else begin
          ctl.rm_key = 1'b1;
        end
      end
      kpq_pkg::OP_EXEC: begin
        // head of the sorted chain is the top task
        if (!head_valid) begin
          out_status_d = kpq_pkg::ST_EMPTY;
        end else begin
          ctl.rm_head = 1'b1;
          out_user_d  = UW'(head_user);
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
    ctl.upd = apply_en;
  end

  kpq_chain #(
    .ENTRIES   (ENTRIES),
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .ins_key_i    ({req_prio_q, req_task_q}),
    .ins_user_i   (ins_user),
    .rm_key_i     (hit_key_q),
    .task_i       (req_task_q),
    .hit_o        (hit),
    .hit_key_o    (hit_key),
    .hit_user_o   (hit_user),
    .head_valid_o (head_valid),
    .head_user_o  (head_user),
    .full_o       (full)
  );

  // result register, loaded in the commit cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (apply_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_en) begin
      out_user_q   <= out_user_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_user_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// ----- rtl/core/kpq_checker.sv -----
// port-level checks of the keyed priority task queue, bound to the top level
// depends on kpq_pkg and keyed_priority_task_queue_top
module kpq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [kpq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [kpq_pkg::STATUS_W-1:0]  m_axis_tuser
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a result with an error status carries a zero user
  a_user_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != kpq_pkg::ST_OK |-> m_axis_tdata == '0)
    else $error("nonzero user with error status");

  // lookup cycle follows every accepted item
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("item accepted during lookup");

  // a fresh result always traces back to an accepted item, through lookup and commit
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_fire, 3))
    else $error("result without matching item");

  // nothing is offered once reset has been seen at an edge
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid in reset");

endmodule

bind keyed_priority_task_queue_top kpq_checker u_kpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/tb_keyed_priority_task_queue_top.sv -----
// self-checking testbench for keyed_priority_task_queue_top: a scoreboard class
// tracks the task table and compares every result with its expected outcome
// depends on kpq_pkg and the rtl under rtl/core
module tb_keyed_priority_task_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kpq_pkg::*;

  localparam int unsigned POOL_SIZE = 24;  // more ids than slots so the table fills

  // expected outcome of one item
  typedef struct packed {
    logic [USER_W-1:0] served;
    st_e               status;
  } outcome_t;

  // shadow copy of the task table plus the queue of outcomes still owed by the block
  class kpq_scoreboard;
    bit                live  [ENTRIES_DEF];
    logic [PRIO_W-1:0] rank  [ENTRIES_DEF];
    logic [USER_W-1:0] owner [ENTRIES_DEF];
    logic [TASK_W-1:0] key   [ENTRIES_DEF];
    outcome_t          owed  [$];
    int unsigned       mismatches;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      mismatches = 0;
    endfunction

    // slot holding the given task id, or -1
    function int find_key(logic [TASK_W-1:0] id);
      int i;
      for (i = 0; i < ENTRIES_DEF; i++)
        if (live[i] && key[i] == id) return i;
      return -1;
    endfunction

    // apply one accepted item to the shadow table and queue its outcome
    function void note_item(op_e op, logic [USER_W-1:0] user, logic [TASK_W-1:0] id,
                            logic [PRIO_W-1:0] prio);
      outcome_t res;
      int       slot;
      int       i;
      res.served = '0;
      res.status = ST_OK;
      case (op)
        OP_ADD: begin
          if (find_key(id) >= 0) begin
            res.status = ST_DUP;
          end else begin
            // lowest free slot
            slot = -1;
            for (i = ENTRIES_DEF - 1; i >= 0; i--)
              if (!live[i]) slot = i;
            if (slot < 0) begin
              res.status = ST_FULL;
            end else begin
              live[slot]  = 1'b1;
              key[slot]   = id;
              owner[slot] = user;
              rank[slot]  = prio;
            end
          end
        end
        OP_EDIT: begin
          slot = find_key(id);
          if (slot < 0) res.status = ST_NOT_FOUND;
          else rank[slot] = prio;
        end
        OP_REMOVE: begin
          slot = find_key(id);
          if (slot < 0) res.status = ST_NOT_FOUND;
          else live[slot] = 1'b0;
        end
        default: begin
          // highest priority wins, ties go to the larger task id
          slot = -1;
          for (i = 0; i < ENTRIES_DEF; i++)
            if (live[i] && (slot < 0 || rank[i] > rank[slot] ||
                            (rank[i] == rank[slot] && key[i] > key[slot])))
              slot = i;
          if (slot < 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.served = owner[slot];
            live[slot] = 1'b0;
          end
        end
      endcase
      owed.push_back(res);
    endfunction

    // compare one accepted result with the oldest owed outcome
    function void check_result(logic [USER_W-1:0] served, logic [STATUS_W-1:0] status);
      outcome_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result served_user %h status %0d", $time, served, status);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (want.served !== served) begin
        $display("%0t: served_user mismatch, expected %h actual %h",
                 $time, want.served, served);
        mismatches++;
      end
      if (want.status !== status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [OP_W-1:0]      s_axis_tuser  = OP_ADD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  kpq_scoreboard     sb = new();
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  bit                hold_rx       = 1'b0;  // request for one long receiver hold-off
  logic [TASK_W-1:0] id_pool [POOL_SIZE];

  keyed_priority_task_queue_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // both handshakes are sampled at the edge, before any of this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(op_e'(s_axis_tuser), s_axis_tdata[USER_LSB +: USER_W],
                     s_axis_tdata[TASK_LSB +: TASK_W], s_axis_tdata[PRIO_LSB +: PRIO_W]);
    end
  end

  // receiver: random back-pressure, or one long hold-off when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one item and wait for its handshake, then maybe leave a gap
  task automatic send_item(op_e op, logic [USER_W-1:0] user, logic [TASK_W-1:0] id,
                           logic [PRIO_W-1:0] prio);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, id, user};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  // random item: ids mostly from a small pool so duplicates, hits and a full table happen,
  // priorities mostly from a narrow range so ties are common
  task automatic rand_item();
    int unsigned       pick;
    op_e               op;
    logic [TASK_W-1:0] id;
    logic [PRIO_W-1:0] prio;
    pick = $urandom_range(99);
    op   = (pick < 40) ? OP_ADD : (pick < 58) ? OP_EDIT : (pick < 72) ? OP_REMOVE : OP_EXEC;
    id   = ($urandom_range(99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                     : TASK_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 50)      prio = $urandom_range(0, 7);
    else if (pick < 60) prio = '0;
    else if (pick < 70) prio = '1;
    else                prio = $urandom;
    send_item(op, USER_W'($urandom), id, prio);
  endtask

  initial begin
    int k;
    int ph;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 78;

    // directed: empty queue, unknown ids, extremes, duplicate, full table, tie on execute
    send_item(OP_EXEC, USER_W'($urandom), TASK_W'($urandom), $urandom);
    send_item(OP_EDIT, USER_W'($urandom), 16'h1234, 32'd9);
    send_item(OP_REMOVE, USER_W'($urandom), 16'h1234, 32'd9);
    send_item(OP_ADD, 16'hFFFF, 16'h0000, 32'h0000_0000);
    send_item(OP_ADD, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(OP_ADD, 16'h5555, 16'h0000, 32'd1);
    for (k = 1; k <= 14; k++) send_item(OP_ADD, USER_W'($urandom), TASK_W'(k), 32'd5);
    send_item(OP_ADD, 16'hAAAA, 16'd100, 32'd7);
    send_item(OP_EDIT, USER_W'($urandom), 16'd3, 32'hFFFF_FFFF);
    send_item(OP_EXEC, USER_W'($urandom), TASK_W'($urandom), $urandom);
    send_item(OP_EXEC, USER_W'($urandom), TASK_W'($urandom), $urandom);
    send_item(OP_REMOVE, USER_W'($urandom), 16'h0000, $urandom);
    drain();

    // three random phases: slow receiver, slow sender, then full speed
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 78 : 0;
      recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 27 : 0;
      foreach (id_pool[i]) id_pool[i] = TASK_W'($urandom);
      id_pool[0] = '0;
      id_pool[1] = '1;
      // full-speed phase starts with a long receiver hold-off so the input stalls
      if (ph == 2) hold_rx = 1'b1;
      for (k = 0; k < 366; k++) rand_item();
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/kpq_pkg.sv
rtl/core/kpq_cell.sv
rtl/core/kpq_chain.sv
rtl/core/keyed_priority_task_queue_top.sv
rtl/core/kpq_checker.sv
dv/tb_keyed_priority_task_queue_top.sv
